>>> hdl/msqrt_pkg.sv
// Shared constants for the modular square root unit.
`default_nettype none
package msqrt_pkg;
   localparam int unsigned SEARCH_LIMIT = 4096;
   localparam int unsigned TRY_BITS     = 13;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_ZERO = 2'd0;
   localparam status_type STATUS_NONE = 2'd1;
   localparam status_type STATUS_TWO  = 2'd2;
endpackage
`default_nettype wire

>>> hdl/modular_square_root_unit.sv
// Modular square root by Cipolla's method around one shared modular multiplier.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+------------------------------------
//  request  | req_n_value, req_modulus                | transfer when start && !busy
//  response | rsp_status, rsp_root_small, rsp_root_large | one-cycle strobe on rsp_valid
//
// Every multiplication mod p runs on one double-and-add unit, one bit per cycle. The
// Euler test and each try of the non-residue search are a power of about 2*MOD_BITS
// multiplies; the extension-field power takes up to 10*MOD_BITS multiplies.
// Synchronous active-high reset clears the sequencer and the response strobe.
// busy stays high from the request transfer until the response strobe; the receiver
// cannot stall, so the response is shown for exactly one cycle.
`default_nettype none
module modular_square_root_unit
   import msqrt_pkg::*;
#(
   parameter int unsigned MOD_BITS = 30
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [MOD_BITS-1:0] req_n_value,
   input  wire logic [MOD_BITS-1:0] req_modulus,
   output logic                     rsp_valid,
   output status_type               rsp_status,
   output logic [MOD_BITS-1:0]      rsp_root_small,
   output logic [MOD_BITS-1:0]      rsp_root_large
);
   localparam int unsigned W  = MOD_BITS;
   localparam int unsigned CW = $clog2(MOD_BITS);
   localparam int unsigned SW = 5;

   // sequencer codes
   localparam logic [SW-1:0] S_IDLE  = 5'd0;
   localparam logic [SW-1:0] S_MUL   = 5'd1;
   localparam logic [SW-1:0] S_CHECK = 5'd2;
   localparam logic [SW-1:0] S_RED_D = 5'd3;
   localparam logic [SW-1:0] S_POW   = 5'd4;
   localparam logic [SW-1:0] S_POW_M = 5'd5;
   localparam logic [SW-1:0] S_POW_S = 5'd6;
   localparam logic [SW-1:0] S_POW_Q = 5'd7;
   localparam logic [SW-1:0] S_EUL_D = 5'd8;
   localparam logic [SW-1:0] S_SRCH  = 5'd9;
   localparam logic [SW-1:0] S_SRC_W = 5'd10;
   localparam logic [SW-1:0] S_SRC_D = 5'd11;
   localparam logic [SW-1:0] S_EXT   = 5'd12;
   localparam logic [SW-1:0] S_E1    = 5'd13;
   localparam logic [SW-1:0] S_E2    = 5'd14;
   localparam logic [SW-1:0] S_E3    = 5'd15;
   localparam logic [SW-1:0] S_E4    = 5'd16;
   localparam logic [SW-1:0] S_E5    = 5'd17;
   localparam logic [SW-1:0] S_E6    = 5'd18;
   localparam logic [SW-1:0] S_FIN   = 5'd19;

   localparam logic [W-1:0] ONE = W'(1);

   function automatic logic [W-1:0] add_m(input logic [W-1:0] x, input logic [W-1:0] y,
                                          input logic [W-1:0] m);
      logic [W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[W-1:0];
   endfunction

   function automatic logic [W-1:0] sub_m(input logic [W-1:0] x, input logic [W-1:0] y,
                                          input logic [W-1:0] m);
      return (x >= y) ? (x - y) : (x - y + m);
   endfunction

   logic [SW-1:0] state_ff, state_in, ret_ff, ret_in;
   logic [W-1:0]  p_ff, p_in, n_ff, n_in;
   logic [W-1:0]  mx_ff, mx_in, my_ff, my_in, macc_ff, macc_in;
   logic [CW-1:0] mcnt_ff, mcnt_in;
   logic [W-1:0]  pbase_ff, pbase_in, pr_ff, pr_in, pe_ff, pe_in;
   logic          pret_ff, pret_in;
   logic [W-1:0]  a_ff, a_in, w2_ff, w2_in;
   logic [TRY_BITS-1:0] tries_ff, tries_in;
   logic [W-1:0]  bre_ff, bre_in, bim_ff, bim_in, are_ff, are_in, aim_ff, aim_in;
   logic [W-1:0]  t_ff, t_in, u_ff, u_in;
   logic          sq_ff, sq_in;
   logic          vld_ff, vld_in;
   status_type    st_ff, st_in;
   logic [W-1:0]  lo_ff, lo_in, hi_ff, hi_in;

   logic [W-1:0]  step_dbl, step_sum, xr, xi, other;

   // one double-and-add step of the shared multiplier
   always_comb begin
      step_dbl = add_m(macc_ff, macc_ff, p_ff);
      step_sum = my_ff[W-1] ? add_m(step_dbl, mx_ff, p_ff) : step_dbl;
   end

   assign xr    = sq_ff ? bre_ff : are_ff;
   assign xi    = sq_ff ? bim_ff : aim_ff;
   assign other = p_ff - are_ff;

   always_comb begin
      state_in = state_ff;  ret_in  = ret_ff;
      p_in     = p_ff;      n_in    = n_ff;
      mx_in    = mx_ff;     my_in   = my_ff;   macc_in = macc_ff;  mcnt_in = mcnt_ff;
      pbase_in = pbase_ff;  pr_in   = pr_ff;   pe_in   = pe_ff;    pret_in = pret_ff;
      a_in     = a_ff;      w2_in   = w2_ff;   tries_in = tries_ff;
      bre_in   = bre_ff;    bim_in  = bim_ff;  are_in  = are_ff;   aim_in  = aim_ff;
      t_in     = t_ff;      u_in    = u_ff;    sq_in   = sq_ff;
      vld_in   = 1'b0;      st_in   = st_ff;   lo_in   = lo_ff;    hi_in   = hi_ff;
      mcnt_in  = (state_ff == S_MUL) ? mcnt_ff - CW'(1) : CW'(W - 1);
      if (state_ff != S_MUL) macc_in = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               p_in     = req_modulus;
               n_in     = req_n_value;
               state_in = S_CHECK;
            end
         end
         S_MUL: begin
            // advance one bit; hand back to the caller after the last
            macc_in = step_sum;
            my_in   = my_ff << 1;
            if (mcnt_ff == '0) state_in = ret_ff;
         end
         S_CHECK: begin
            if (p_ff < W'(3) || !p_ff[0]) begin
               vld_in = 1'b1; st_in = STATUS_NONE; lo_in = '0; hi_in = '0;
               state_in = S_IDLE;
            end else begin
               // n mod p as 1 * n through the multiplier
               mx_in = ONE; my_in = n_ff; ret_in = S_RED_D; state_in = S_MUL;
            end
         end
         S_RED_D: begin
            n_in = macc_ff;
            if (macc_ff == '0) begin
               vld_in = 1'b1; st_in = STATUS_ZERO; lo_in = '0; hi_in = '0;
               state_in = S_IDLE;
            end else begin
               pbase_in = macc_ff; pr_in = ONE; pe_in = p_ff >> 1; pret_in = 1'b0;
               state_in = S_POW;
            end
         end
         S_POW: begin
            if (pe_ff == '0) state_in = pret_ff ? S_SRC_D : S_EUL_D;
            else if (pe_ff[0]) begin
               mx_in = pr_ff; my_in = pbase_ff; ret_in = S_POW_M; state_in = S_MUL;
            end else state_in = S_POW_S;
         end
         S_POW_M: begin
            pr_in = macc_ff; state_in = S_POW_S;
         end
         S_POW_S: begin
            mx_in = pbase_ff; my_in = pbase_ff; ret_in = S_POW_Q; state_in = S_MUL;
         end
         S_POW_Q: begin
            pbase_in = macc_ff; pe_in = pe_ff >> 1; state_in = S_POW;
         end
         S_EUL_D: begin
            if (pr_ff == p_ff - ONE) begin
               vld_in = 1'b1; st_in = STATUS_NONE; lo_in = '0; hi_in = '0;
               state_in = S_IDLE;
            end else begin
               a_in = ONE; tries_in = '0; state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (tries_ff == TRY_BITS'(SEARCH_LIMIT - 1) + TRY_BITS'(1) || a_ff >= p_ff) begin
               vld_in = 1'b1; st_in = STATUS_NONE; lo_in = '0; hi_in = '0;
               state_in = S_IDLE;
            end else begin
               mx_in = a_ff; my_in = a_ff; ret_in = S_SRC_W; state_in = S_MUL;
            end
         end
         S_SRC_W: begin
            w2_in    = sub_m(macc_ff, n_ff, p_ff);
            pbase_in = sub_m(macc_ff, n_ff, p_ff);
            pr_in = ONE; pe_in = p_ff >> 1; pret_in = 1'b1; state_in = S_POW;
         end
         S_SRC_D: begin
            if (pr_ff == p_ff - ONE) begin
               bre_in = a_ff; bim_in = ONE; are_in = ONE; aim_in = '0;
               pe_in  = (p_ff >> 1) + ONE;
               state_in = S_EXT;
            end else begin
               a_in = a_ff + ONE; tries_in = tries_ff + TRY_BITS'(1); state_in = S_SRCH;
            end
         end
         S_EXT: begin
            if (pe_ff == '0) state_in = S_FIN;
            else begin
               sq_in = !pe_ff[0]; state_in = S_E1;
            end
         end
         S_E1: begin
            mx_in = xr; my_in = bre_ff; ret_in = S_E2; state_in = S_MUL;
         end
         S_E2: begin
            t_in = macc_ff; mx_in = xi; my_in = bim_ff; ret_in = S_E3; state_in = S_MUL;
         end
         S_E3: begin
            mx_in = w2_ff; my_in = macc_ff; ret_in = S_E4; state_in = S_MUL;
         end
         S_E4: begin
            t_in = add_m(t_ff, macc_ff, p_ff);
            mx_in = xr; my_in = bim_ff; ret_in = S_E5; state_in = S_MUL;
         end
         S_E5: begin
            u_in = macc_ff; mx_in = xi; my_in = bre_ff; ret_in = S_E6; state_in = S_MUL;
         end
         S_E6: begin
            if (sq_ff) begin
               bre_in = t_ff; bim_in = add_m(u_ff, macc_ff, p_ff);
               pe_in = pe_ff >> 1; state_in = S_EXT;
            end else begin
               // multiply done; square the base next
               are_in = t_ff; aim_in = add_m(u_ff, macc_ff, p_ff);
               sq_in = 1'b1; state_in = S_E1;
            end
         end
         S_FIN: begin
            vld_in = 1'b1; state_in = S_IDLE;
            if (are_ff == '0) begin
               st_in = STATUS_ZERO; lo_in = '0; hi_in = '0;
            end else begin
               st_in = STATUS_TWO;
               lo_in = (are_ff < other) ? are_ff : other;
               hi_in = (are_ff < other) ? other : are_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
      ret_ff <= ret_in;   p_ff <= p_in;   n_ff <= n_in;
      mx_ff <= mx_in;     my_ff <= my_in; macc_ff <= macc_in; mcnt_ff <= mcnt_in;
      pbase_ff <= pbase_in; pr_ff <= pr_in; pe_ff <= pe_in; pret_ff <= pret_in;
      a_ff <= a_in;       w2_ff <= w2_in; tries_ff <= tries_in;
      bre_ff <= bre_in;   bim_ff <= bim_in; are_ff <= are_in; aim_ff <= aim_in;
      t_ff <= t_in;       u_ff <= u_in;   sq_ff <= sq_in;
      st_ff <= st_in;     lo_ff <= lo_in; hi_ff <= hi_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = vld_ff;
   assign rsp_status     = st_ff;
   assign rsp_root_small = lo_ff;
   assign rsp_root_large = hi_ff;

   // a response only ever appears once the sequencer is back at rest
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");
   // a request transfer always starts work
   a_take: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("request dropped");
   // no two responses in a row
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("repeated response");
   // without two roots both roots read zero
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_TWO |-> rsp_root_small == '0 && rsp_root_large == '0)
      else $error("stray root");
endmodule
`default_nettype wire

>>> tb/sv/modular_square_root_unit_tb.sv
// Self-checking testbench for the modular square root unit.
`timescale 1ns / 100ps
`default_nettype none
module modular_square_root_unit_tb
   import msqrt_pkg::*;
();

   localparam int unsigned MOD_BITS = 30;
   localparam int unsigned TRY_LIMIT = SEARCH_LIMIT;
   // used as the settling time at the end
   localparam int unsigned DRAIN_CYCLES = 40000;

   typedef logic [MOD_BITS-1:0] word_type;

   typedef struct packed {
      word_type n_value;
      word_type modulus;
   } sqrt_request_type;

   typedef struct packed {
      status_type status;
      word_type   root_small;
      word_type   root_large;
   } sqrt_answer_type;

   logic  clock = 1'b0;
   logic  reset = 1'b1;
   logic  start = 1'b0;
   word_type req_n_value = '0;
   word_type req_modulus = '0;
   logic  busy;
   logic  rsp_valid;
   status_type rsp_status;
   word_type rsp_root_small;
   word_type rsp_root_large;

   sqrt_request_type pending_requests[$];
   sqrt_answer_type  awaited_answers[$];
   int unsigned   transfers_taken = 0;
   int unsigned   sender_idle_pct = 37;
   int unsigned   error_count = 0;

   modular_square_root_unit #(.MOD_BITS(MOD_BITS)) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_n_value(req_n_value),
      .req_modulus(req_modulus),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_root_small(rsp_root_small),
      .rsp_root_large(rsp_root_large)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Products of two values below 2^30 fit comfortably in 64 bits.
   function automatic longint unsigned mod_mul(longint unsigned x, longint unsigned y,
                                               longint unsigned m);
      return (x * y) % m;
   endfunction

   function automatic longint unsigned mod_pow(longint unsigned b, longint unsigned e,
                                               longint unsigned m);
      longint unsigned r;
      r = 1 % m;
      while (e != 0) begin
         if (e[0]) r = mod_mul(r, b, m);
         b = mod_mul(b, b, m);
         e = e >> 1;
      end
      return r;
   endfunction

   // Work out the expected roots of one request by Cipolla's method.
   function automatic sqrt_answer_type cipolla_roots(sqrt_request_type rq);
      sqrt_answer_type ans;
      longint unsigned p, n, half, a, w2, e, br, bi, ar, ai, tr, ti, r, other;
      int unsigned tries;
      bit found;
      ans = '{STATUS_NONE, '0, '0};
      p = rq.modulus;
      found = 1'b0;
      w2 = 0;
      if (p < 3 || p[0] == 1'b0) return ans;
      n = rq.n_value % p;
      if (n == 0) begin
         ans.status = STATUS_ZERO;
         return ans;
      end
      half = (p - 1) >> 1;
      if (mod_pow(n, half, p) == p - 1) return ans;
      a = 1;
      for (tries = 0; tries < TRY_LIMIT && a < p; tries++) begin
         w2 = (mod_mul(a, a, p) + p - n) % p;
         if (mod_pow(w2, half, p) == p - 1) begin
            found = 1'b1;
            break;
         end
         a++;
      end
      if (!found) return ans;
      // (a + w)^((p+1)/2) in GF(p)[w], w*w = w2
      br = a; bi = 1; ar = 1; ai = 0;
      e = (p >> 1) + 1;
      while (e != 0) begin
         if (e[0]) begin
            tr = (mod_mul(ar, br, p) + mod_mul(w2, mod_mul(ai, bi, p), p)) % p;
            ti = (mod_mul(ar, bi, p) + mod_mul(ai, br, p)) % p;
            ar = tr; ai = ti;
         end
         tr = (mod_mul(br, br, p) + mod_mul(w2, mod_mul(bi, bi, p), p)) % p;
         ti = (mod_mul(br, bi, p) + mod_mul(bi, br, p)) % p;
         br = tr; bi = ti;
         e = e >> 1;
      end
      r = ar;
      if (r == 0) begin
         ans.status = STATUS_ZERO;
         return ans;
      end
      other = p - r;
      ans.status = STATUS_TWO;
      ans.root_small = word_type'((r < other) ? r : other);
      ans.root_large = word_type'((r < other) ? other : r);
      return ans;
   endfunction

   // Driver: hold start until the transfer, then roll for the next request.
   always @(posedge clock) begin
      logic took;
      logic next_start;
      took = 1'b0;
      next_start = start;
      if (!reset) begin
         if (start && !busy) begin
            awaited_answers.push_back(cipolla_roots(pending_requests.pop_front()));
            transfers_taken <= transfers_taken + 1;
            took = 1'b1;
         end
         if (took || !start) begin
            next_start = 1'b0;
            if (pending_requests.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct) begin
               next_start = 1'b1;
               req_n_value <= pending_requests[0].n_value;
               req_modulus <= pending_requests[0].modulus;
            end
         end
         start <= next_start;
      end
   end

   // Idling phases: sender idles 37 then 64 in a hundred, then not at all.
   always @(posedge clock) begin
      if (transfers_taken >= 100) sender_idle_pct <= 0;
      else if (transfers_taken >= 50) sender_idle_pct <= 64;
      else sender_idle_pct <= 37;
   end

   // Monitor: compare each strobed response with the oldest awaited answer.
   always @(posedge clock) begin
      sqrt_answer_type want;
      if (!reset && rsp_valid) begin
         if (awaited_answers.size() == 0) begin
            $display("%0t: response with nothing awaited: status %0d roots %0d %0d",
                     $time, rsp_status, rsp_root_small, rsp_root_large);
            error_count <= error_count + 1;
         end else begin
            want = awaited_answers.pop_front();
            if (rsp_status !== want.status || rsp_root_small !== want.root_small ||
                rsp_root_large !== want.root_large) begin
               $display("%0t: mismatch expected %0d %0d %0d actual %0d %0d %0d", $time,
                        want.status, want.root_small, want.root_large,
                        rsp_status, rsp_root_small, rsp_root_large);
               error_count <= error_count + 1;
            end
         end
      end
   end

   // Fill the request queue, release reset, drain and report.
   initial begin
      word_type primes[12];
      word_type composites[6];
      word_type p;
      word_type x;
      int unsigned pick;
      primes = '{3, 5, 7, 11, 13, 17, 97, 65521, 1000003, 998244353,
                 1073741783, 1073741789};
      composites = '{9, 15, 21, 25, 27, 33};
      // directed: bad moduli, zero, non-residue, roots, extremes, composites
      pending_requests.push_back('{0, 0});
      pending_requests.push_back('{5, 1});
      pending_requests.push_back('{5, 2});
      pending_requests.push_back('{7, 1073741822});
      pending_requests.push_back('{0, 3});
      pending_requests.push_back('{1073741789, 1073741789});
      pending_requests.push_back('{1, 3});
      pending_requests.push_back('{2, 3});
      pending_requests.push_back('{4, 5});
      pending_requests.push_back('{2, 5});
      pending_requests.push_back('{10, 13});
      pending_requests.push_back('{1073741823, 1073741789});
      pending_requests.push_back('{1073741823, 3});
      pending_requests.push_back('{1, 1073741789});
      pending_requests.push_back('{1073741788, 1073741789});
      pending_requests.push_back('{4, 1073741783});
      pending_requests.push_back('{1, 9});
      pending_requests.push_back('{4, 15});
      pending_requests.push_back('{7, 25});
      pending_requests.push_back('{1, 1073741823});
      for (int i = 0; i < 130; i++) begin
         pick = $urandom_range(99);
         p = primes[$urandom_range(11)];
         x = word_type'($urandom);
         if (pick < 40) begin
            pending_requests.push_back('{x, p});
         end else if (pick < 65) begin
            // well-formed residue: square of a random value
            x = word_type'(mod_mul(x % p, x % p, p) + p * $urandom_range(1));
            pending_requests.push_back('{x, p});
         end else if (pick < 75) begin
            pending_requests.push_back('{x, word_type'($urandom) & ~word_type'(1)});
         end else if (pick < 83) begin
            pending_requests.push_back('{word_type'(p * $urandom_range(3)), p});
         end else if (pick < 93) begin
            pending_requests.push_back('{x, composites[$urandom_range(5)]});
         end else begin
            pending_requests.push_back('{x, word_type'($urandom_range(2))});
         end
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (pending_requests.size() != 0 || awaited_answers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && awaited_answers.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #400000000;
      $display("TEST FAILED");
      $finish;
   end
endmodule
`default_nettype wire
